// ===== hdl/rslt_pkg.sv =====
// Shared types and constants for the response slot liveness tracker.
package rslt_pkg;

  localparam int NUM_SLOTS_DEF = 32;
  localparam int MASK_W        = 32;
  localparam int SLOT_W        = 8;
  localparam int CNT_W         = 8;

  localparam logic [CNT_W-1:0] CNT_MAX      = 8'hFF;
  localparam logic [CNT_W-1:0] THRESH_RESET = 8'd4;

  typedef enum logic [1:0] {
    ACT_SET  = 2'd0,
    ACT_CLR  = 2'd1,
    ACT_RESP = 2'd2,
    ACT_TICK = 2'd3
  } act_t;

  typedef struct packed {
    logic              exec;
    act_t              action;
    logic [SLOT_W-1:0] slot;
    logic              payload;
    logic [CNT_W-1:0]  threshold;
  } cell_cmd_t;

  typedef struct packed {
    logic exp_nxt;
    logic retx;
    logic rel;
  } cell_stat_t;

endpackage

// ===== hdl/rslt_cell.sv =====
// One slot cell: expected and received flags and the saturating miss counter.
module rslt_cell #(
  parameter int IDX = 0
) (
  input  logic                clk,
  input  logic                rst_n,
  input  rslt_pkg::cell_cmd_t cmd,
  output rslt_pkg::cell_stat_t stat
);
  import rslt_pkg::*;

  logic             exp_r, exp_nxt;
  logic             rcv_r, rcv_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             sel;
  logic             miss;
  logic [CNT_W-1:0] cnt_inc;
  logic             rel;

  assign sel     = (cmd.slot == SLOT_W'(IDX));
  assign miss    = exp_r && !rcv_r;
  assign cnt_inc = (cnt_r == CNT_MAX) ? CNT_MAX : cnt_r + 1'b1;

  always_comb begin
    exp_nxt = exp_r;
    rcv_nxt = rcv_r;
    cnt_nxt = cnt_r;
    rel     = 1'b0;
    if (cmd.exec) begin
      unique case (cmd.action)
        ACT_SET: begin
          if (sel) begin
            exp_nxt = 1'b1;
          end
        end
        ACT_CLR: begin
          if (sel) begin
            exp_nxt = 1'b0;
            cnt_nxt = '0;
          end
        end
        ACT_RESP: begin
          if (sel && cmd.payload) begin
            rcv_nxt = 1'b1;
          end
        end
        ACT_TICK: begin
          if (miss) begin
            if (cnt_inc >= cmd.threshold) begin
              exp_nxt = 1'b0;
              cnt_nxt = '0;
              rel     = 1'b1;
            end else begin
              cnt_nxt = cnt_inc;
            end
          end else if (rcv_r) begin
            cnt_nxt = '0;
          end
          rcv_nxt = 1'b0;
        end
        default: begin
          exp_nxt = exp_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_r <= 1'b0;
      rcv_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      exp_r <= exp_nxt;
      rcv_r <= rcv_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  assign stat.exp_nxt = exp_nxt;
  assign stat.retx    = cmd.exec && (cmd.action == ACT_TICK) && miss;
  assign stat.rel     = rel;

endmodule

// ===== hdl/response_slot_liveness_tracker.sv =====
// Top level of the response slot liveness tracker: command register, slot cells, result register.
// Each transaction is handled in steps: the command register captures it, then, once the result
// register is free or being read, every slot cell updates at once and the result register loads.
// A new input transaction is taken once the registered command has been executed, so the tracker
// cannot take a new item before it is through with the last. Slots at or above NUM_SLOTS are
// reported as ignored, except on a tick, and only slots 0 to 31 appear in the masks.
module response_slot_liveness_tracker #(
  parameter int NUM_SLOTS = rslt_pkg::NUM_SLOTS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_wr_en,
  input  logic [7:0]   cfg_wr_data,   // idle_threshold
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [15:0]  in_tdata,      // action[1:0], slot[9:2], has_payload[10], zero fill
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [103:0] out_tdata      // expected_mask[31:0], retransmit_mask[63:32],
                                      // released_mask[95:64], ignored[96], zero fill
);
  import rslt_pkg::*;

  logic [CNT_W-1:0]  threshold_r;
  logic              cmd_valid_r, cmd_valid_nxt;
  act_t              cmd_action_r;
  logic [SLOT_W-1:0] cmd_slot_r;
  logic              cmd_payload_r;
  logic              exec;
  logic              in_range;
  logic              ign;
  cell_cmd_t         cmd;
  cell_stat_t        stat [NUM_SLOTS];
  logic [MASK_W-1:0] exp_mask, retx_mask, rel_mask;
  logic              out_valid_r, out_valid_nxt;
  logic [MASK_W-1:0] exp_mask_r, retx_mask_r, rel_mask_r;
  logic              ign_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= THRESH_RESET;
    end else if (cfg_wr_en) begin
      threshold_r <= cfg_wr_data;
    end
  end

  assign in_tready = !cmd_valid_r;
  assign exec      = cmd_valid_r && (!out_valid_r || out_tready);

  always_comb begin
    cmd_valid_nxt = cmd_valid_r;
    if (in_tvalid && in_tready) begin
      cmd_valid_nxt = 1'b1;
    end else if (exec) begin
      cmd_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_valid_r <= 1'b0;
    end else begin
      cmd_valid_r <= cmd_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      cmd_action_r  <= act_t'(in_tdata[1:0]);
      cmd_slot_r    <= in_tdata[9:2];
      cmd_payload_r <= in_tdata[10];
    end
  end

  assign cmd.exec      = exec;
  assign cmd.action    = cmd_action_r;
  assign cmd.slot      = cmd_slot_r;
  assign cmd.payload   = cmd_payload_r;
  assign cmd.threshold = threshold_r;

  for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
    rslt_cell #(.IDX(i)) u_cell (
      .clk  (clk),
      .rst_n(rst_n),
      .cmd  (cmd),
      .stat (stat[i])
    );
  end

  for (genvar j = 0; j < MASK_W; j++) begin : g_mask
    if (j < NUM_SLOTS) begin : g_live
      assign exp_mask[j]  = stat[j].exp_nxt;
      assign retx_mask[j] = stat[j].retx;
      assign rel_mask[j]  = stat[j].rel;
    end else begin : g_none
      assign exp_mask[j]  = 1'b0;
      assign retx_mask[j] = 1'b0;
      assign rel_mask[j]  = 1'b0;
    end
  end

  assign in_range = (cmd_slot_r < SLOT_W'(NUM_SLOTS));
  assign ign      = (cmd_action_r != ACT_TICK) &&
                    (!in_range || ((cmd_action_r == ACT_RESP) && !cmd_payload_r));

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (exec) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      exp_mask_r  <= exp_mask;
      retx_mask_r <= retx_mask;
      rel_mask_r  <= rel_mask;
      ign_r       <= ign;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, ign_r, rel_mask_r, retx_mask_r, exp_mask_r};

endmodule

// ===== bench/tb_response_slot_liveness_tracker.sv =====
// Self-checking testbench for the response slot liveness tracker, with a predicting scoreboard.
module tb_response_slot_liveness_tracker;
  import rslt_pkg::*;

  localparam int SLOTS = NUM_SLOTS_DEF;

  typedef struct {
    logic [MASK_W-1:0] expected_mask;
    logic [MASK_W-1:0] retransmit_mask;
    logic [MASK_W-1:0] released_mask;
    logic              ignored;
  } slot_report_t;

  class liveness_scoreboard;
    logic [SLOTS-1:0] expected_bits;
    logic [SLOTS-1:0] received_bits;
    logic [CNT_W-1:0] miss_count [SLOTS];
    logic [CNT_W-1:0] threshold;
    slot_report_t     due_reports[$];
    int unsigned      errors;
    int unsigned      reports_seen;
    int unsigned      ticks_seen;
    int unsigned      releases_seen;
    int unsigned      dropped_seen;

    function new();
      expected_bits = '0;
      received_bits = '0;
      foreach (miss_count[i]) miss_count[i] = '0;
      threshold = THRESH_RESET;
      errors = 0;
      reports_seen = 0;
      ticks_seen = 0;
      releases_seen = 0;
      dropped_seen = 0;
    endfunction

    function void note_item(act_t action, logic [SLOT_W-1:0] slot, logic payload);
      slot_report_t rep;
      logic         in_range;
      in_range = slot < SLOTS;
      rep.retransmit_mask = '0;
      rep.released_mask = '0;
      rep.ignored = 1'b0;
      case (action)
        ACT_SET: begin
          if (in_range) expected_bits[slot] = 1'b1;
          else rep.ignored = 1'b1;
        end
        ACT_CLR: begin
          if (in_range) begin
            expected_bits[slot] = 1'b0;
            miss_count[slot] = '0;
          end else begin
            rep.ignored = 1'b1;
          end
        end
        ACT_RESP: begin
          if (payload && in_range) received_bits[slot] = 1'b1;
          else rep.ignored = 1'b1;
        end
        default: begin
          for (int i = 0; i < SLOTS; i++) begin
            if (expected_bits[i] && !received_bits[i]) begin
              rep.retransmit_mask[i] = 1'b1;
              if (miss_count[i] != CNT_MAX) miss_count[i] = miss_count[i] + 1'b1;
              if (miss_count[i] >= threshold) begin
                expected_bits[i] = 1'b0;
                miss_count[i] = '0;
                rep.released_mask[i] = 1'b1;
              end
            end else if (received_bits[i]) begin
              miss_count[i] = '0;
            end
            received_bits[i] = 1'b0;
          end
        end
      endcase
      rep.expected_mask = expected_bits;
      due_reports.push_back(rep);
    endfunction

    function void check_report(logic [103:0] data);
      slot_report_t want;
      slot_report_t got;
      got.expected_mask = data[31:0];
      got.retransmit_mask = data[63:32];
      got.released_mask = data[95:64];
      got.ignored = data[96];
      if (due_reports.size() == 0) begin
        $error("result transaction with nothing expected: %h", data);
        errors++;
        return;
      end
      want = due_reports.pop_front();
      reports_seen++;
      if (want.released_mask != '0 || want.retransmit_mask != '0) ticks_seen++;
      releases_seen += $countones(want.released_mask);
      if (want.ignored) dropped_seen++;
      if (got.expected_mask !== want.expected_mask) begin
        $error("expected_mask: expected %h, actual %h", want.expected_mask, got.expected_mask);
        errors++;
      end
      if (got.retransmit_mask !== want.retransmit_mask) begin
        $error("retransmit_mask: expected %h, actual %h",
               want.retransmit_mask, got.retransmit_mask);
        errors++;
      end
      if (got.released_mask !== want.released_mask) begin
        $error("released_mask: expected %h, actual %h", want.released_mask, got.released_mask);
        errors++;
      end
      if (got.ignored !== want.ignored) begin
        $error("ignored: expected %b, actual %b", want.ignored, got.ignored);
        errors++;
      end
    endfunction
  endclass

  logic         clk;
  logic         rst_n;
  logic         cfg_wr_en;
  logic [7:0]   cfg_wr_data;
  logic         in_tvalid;
  logic         in_tready;
  logic [15:0]  in_tdata;       // action[1:0], slot[9:2], has_payload[10], zero fill
  logic         out_tvalid;
  logic         out_tready;
  logic [103:0] out_tdata;      // expected_mask[31:0], retransmit_mask[63:32],
                                // released_mask[95:64], ignored[96], zero fill

  liveness_scoreboard board;
  logic               steady;
  logic               hold_request;
  int unsigned        hold_left;

  response_slot_liveness_tracker DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #2000000;
    $display("response_slot_liveness_tracker: mismatch");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) board.check_report(out_tdata);
  end

  initial begin
    out_tready = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        out_tready = 1'b0;
        hold_left--;
      end else if (steady) begin
        out_tready = 1'b1;
      end else begin
        out_tready = $urandom_range(99) >= 12;
      end
    end
  end

  task automatic send_item(act_t action, logic [SLOT_W-1:0] slot, logic payload);
    if (!steady && $urandom_range(99) < 12) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(3, 1)) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata = {5'b0, payload, slot, action};
    do @(posedge clk); while (!in_tready);
    board.note_item(action, slot, payload);
    @(negedge clk);
  endtask

  task automatic drain();
    in_tvalid = 1'b0;
    while (board.due_reports.size() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic write_threshold(logic [7:0] value);
    drain();
    cfg_wr_en = 1'b1;
    cfg_wr_data = value;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    board.threshold = value;
  endtask

  initial begin
    int unsigned      r;
    act_t             action;
    logic [SLOT_W-1:0] slot;
    logic [7:0]       thr;

    board = new();
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    steady = 1'b0;
    hold_request = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Reset threshold: range checks, empty responses, clearing and an idle release.
    send_item(ACT_SET, 8'd0, 1'b0);
    send_item(ACT_SET, 8'd31, 1'b1);
    send_item(ACT_SET, 8'd32, 1'b1);
    send_item(ACT_SET, 8'd255, 1'b0);
    send_item(ACT_RESP, 8'd0, 1'b1);
    send_item(ACT_RESP, 8'd31, 1'b0);
    send_item(ACT_RESP, 8'd40, 1'b1);
    send_item(ACT_RESP, 8'd255, 1'b0);
    send_item(ACT_CLR, 8'd32, 1'b0);
    send_item(ACT_CLR, 8'd255, 1'b1);
    send_item(ACT_TICK, 8'd255, 1'b1);
    send_item(ACT_TICK, 8'd0, 1'b0);
    send_item(ACT_SET, 8'd17, 1'b0);
    send_item(ACT_CLR, 8'd17, 1'b0);
    send_item(ACT_SET, 8'd16, 1'b0);
    send_item(ACT_TICK, 8'd0, 1'b0);
    send_item(ACT_CLR, 8'd16, 1'b0);
    send_item(ACT_SET, 8'd16, 1'b0);
    send_item(ACT_RESP, 8'd16, 1'b1);
    send_item(ACT_TICK, 8'd0, 1'b0);
    send_item(ACT_TICK, 8'd0, 1'b0);
    send_item(ACT_TICK, 8'd0, 1'b0);

    // A threshold of zero releases a slot on its first miss.
    write_threshold(8'd0);
    send_item(ACT_SET, 8'd3, 1'b0);
    send_item(ACT_SET, 8'd4, 1'b0);
    send_item(ACT_RESP, 8'd4, 1'b1);
    send_item(ACT_TICK, 8'd0, 1'b0);

    // The largest threshold lets a counter climb all the way to its top value, where the slot is released.
    write_threshold(8'd255);
    send_item(ACT_SET, 8'd7, 1'b0);
    send_item(ACT_SET, 8'd8, 1'b0);
    for (int n = 0; n < 256; n++) begin
      if (n % 10 == 0) send_item(ACT_RESP, 8'd8, 1'b1);
      send_item(ACT_TICK, SLOT_W'($urandom_range(255)), 1'($urandom_range(1)));
    end

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: thr = 8'd3;
        1: thr = 8'd1;
        2: thr = 8'd2;
        3: thr = 8'd6;
        4: thr = 8'd255;
        5: thr = 8'd0;
        6: thr = 8'd4;
        default: thr = 8'($urandom_range(255, 1));
      endcase
      write_threshold(thr);
      steady = (ph == 2);
      if (ph == 4) hold_request = 1'b1;
      for (int n = 0; n < 117; n++) begin
        r = $urandom_range(99);
        if (r < 25) action = ACT_SET;
        else if (r < 35) action = ACT_CLR;
        else if (r < 70) action = ACT_RESP;
        else action = ACT_TICK;
        if ($urandom_range(9) == 0) slot = SLOT_W'($urandom_range(255, 32));
        else slot = SLOT_W'($urandom_range(SLOTS - 1));
        send_item(action, slot, $urandom_range(99) < 85);
      end
    end
    steady = 1'b0;

    drain();
    repeat (10) @(negedge clk);
    $display("Covered %0d transactions, %0d of them ticks with missing slots, %0d releases",
             board.reports_seen, board.ticks_seen, board.releases_seen);
    $display("and %0d dropped transactions, over thresholds 0, 1, 255 and several between.",
             board.dropped_seen);
    if (board.errors == 0 && board.due_reports.size() == 0) begin
      $display("response_slot_liveness_tracker: match");
    end else begin
      $display("response_slot_liveness_tracker: mismatch");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/rslt_pkg.sv
hdl/rslt_cell.sv
hdl/response_slot_liveness_tracker.sv
bench/tb_response_slot_liveness_tracker.sv
